// ===== hdl/heightmap_box_smoother_top_macros.svh =====
// Assertion macros for the height map smoother checker.
// Used by hbs_checker; the macros expect i_clk and i_rst_n in scope.
`ifndef HEIGHTMAP_BOX_SMOOTHER_TOP_MACROS_SVH
`define HEIGHTMAP_BOX_SMOOTHER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hbs_pkg.sv =====
// Shared constants and helpers for the height map 3x3 box smoother.
// No dependencies; used by heightmap_box_smoother_top and hbs_checker.
package hbs_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int FW_W         = 12;
    localparam int FH_W         = 13;
    localparam int CFG_W        = 13;
    localparam int PIX_W        = 8;
    localparam int MEAN_W       = 16;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 12'd256;
    localparam logic [FH_W-1:0] FH_RESET = 13'd256;

    localparam logic [MEAN_W-1:0] MEAN_MAX = 16'hFF00;

    // Reciprocal divide: floor(num * recip(n) >> RECIP_SHIFT) is exact for
    // num < 2^20 and n in {1,2,3,4,6,9}.
    localparam int SUM_W       = 12;
    localparam int NUM_W       = SUM_W + 8;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(2**RECIP_SHIFT);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(2**(RECIP_SHIFT-1));
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((2**RECIP_SHIFT + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(2**(RECIP_SHIFT-2));
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((2**RECIP_SHIFT + 4) / 6);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((2**RECIP_SHIFT + 8) / 9);

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd2:    r = RECIP_2;
            4'd3:    r = RECIP_3;
            4'd4:    r = RECIP_4;
            4'd6:    r = RECIP_6;
            4'd9:    r = RECIP_9;
            default: r = RECIP_1;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/heightmap_box_smoother_top.sv =====
// Height map 3x3 box smoother with edge-normalized mean, 8.8 output.
// Depends on hbs_pkg.
//
// Input stream: tdata carries one 8-bit height sample per item in raster
// order, tuser is the pad flag. Pads are ignored until all frame_height
// rows are in; after the last sample the source sends frame_width+1 pads,
// which push out the remaining results. tlast on the output marks the
// frame's last pixel.
// Output stream: tdata is the neighborhood mean, unsigned 8.8, rounded.
// A pixel's result is caused by the item frame_width+1 places after its
// sample; after that item is accepted, the result passes stages 1, 2 and 3
// and the output queue. Throughput: one item per clock while input ready is
// high. Two line stores (one read, one write per cycle) are read at accept
// and written back the next cycle; a same-column rewrite one item later is
// forwarded. Results wait in an 8-entry output queue; input ready drops
// when the queue plus results in flight would fill it, so a stalled
// receiver stops the input after a few items and nothing is lost.
// Reset clears counters, window, queue and sets both sizes to 256. Config
// writes take effect on the next cycle and belong between frames.
module heightmap_box_smoother_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] height
    input  logic        i_s_axis_tuser,    // [0] pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,    // [15:0] smoothed_height
    output logic        o_m_axis_tlast     // frame_end
);

    localparam int AW  = hbs_pkg::ADDR_W;
    localparam int FWW = hbs_pkg::FW_W;
    localparam int FHW = hbs_pkg::FH_W;
    localparam int PW  = hbs_pkg::PIX_W;
    localparam int QW  = hbs_pkg::MEAN_W + 1;

    // Configuration
    logic [FWW-1:0] r_cfg_w;
    logic [FHW-1:0] r_cfg_h;
    logic [FWW-1:0] w_eff;
    logic [FHW-1:0] h_eff;

    // Position counters
    logic [AW-1:0]  r_in_col, n_in_col;
    logic [FHW-1:0] r_in_row, n_in_row;
    logic [AW-1:0]  r_out_col, n_out_col;
    logic [FHW-1:0] r_out_row, n_out_row;

    logic           acc, act, flushing, col0, emit, last;
    logic [PW-1:0]  x_in;

    // Line stores
    logic [PW-1:0]  mem_up  [hbs_pkg::MAX_WIDTH];
    logic [PW-1:0]  mem_mid [hbs_pkg::MAX_WIDTH];
    logic [PW-1:0]  r_up_q, r_mid_q;
    logic [PW-1:0]  r_fw_up, r_fw_mid;

    // Stage 1: memory data and window
    logic           r_s1_valid;
    logic [PW-1:0]  r_s1_x;
    logic [AW-1:0]  r_s1_addr;
    logic           r_s1_emit, r_s1_last, r_s1_col0, r_s1_fwd;
    logic [AW-1:0]  r_s1_ocol;
    logic [FHW-1:0] r_s1_orow;

    logic [PW-1:0]  r_win [3][3];
    logic [PW-1:0]  n_win [3][3];
    logic [PW-1:0]  up_eff, mid_eff;
    logic           top_ok, bot_ok, left_ok, right_ok;
    logic [9:0]     row_sum [3];
    logic [hbs_pkg::SUM_W-1:0] sum;
    logic [1:0]     rows, cols;
    logic [3:0]     cnt_n;
    logic [hbs_pkg::NUM_W-1:0] num;

    // Stage 2: divide operands
    logic           r_s2_valid, r_s2_last;
    logic [hbs_pkg::NUM_W-1:0]   r_s2_num;
    logic [hbs_pkg::RECIP_W-1:0] r_s2_recip;

    // Stage 3: product
    logic           r_s3_valid, r_s3_last;
    logic [hbs_pkg::PROD_W-1:0] r_s3_prod;

    // Output queue
    logic [QW-1:0]  q_mem [hbs_pkg::FIFO_DEPTH];
    logic [hbs_pkg::FIFO_AW-1:0] r_q_rd, r_q_wr;
    logic [hbs_pkg::FIFO_AW:0]   r_q_cnt;
    logic           q_pop;
    logic [1:0]     inflight;
    logic [hbs_pkg::FIFO_AW+1:0] occupancy;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = FWW'(1);
        end else if (r_cfg_w > FWW'(hbs_pkg::MAX_WIDTH)) begin
            w_eff = FWW'(hbs_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = FHW'(1);
        end else if (r_cfg_h > FHW'(hbs_pkg::HEIGHT_LIMIT)) begin
            h_eff = FHW'(hbs_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = r_cfg_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= hbs_pkg::FW_RESET;
            r_cfg_h <= hbs_pkg::FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                hbs_pkg::CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_wdata[FWW-1:0];
                hbs_pkg::CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_wdata[FHW-1:0];
                default: ;
            endcase
        end
    end

    // Accept-side control
    assign inflight  = 2'(r_s1_valid & r_s1_emit) + 2'(r_s2_valid) + 2'(r_s3_valid);
    assign occupancy = (hbs_pkg::FIFO_AW+2)'(r_q_cnt) + (hbs_pkg::FIFO_AW+2)'(inflight);
    assign o_s_axis_tready = occupancy < (hbs_pkg::FIFO_AW+2)'(hbs_pkg::FIFO_DEPTH);

    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign flushing = r_in_row >= h_eff;
    assign act      = acc && (flushing || !i_s_axis_tuser);
    assign x_in     = flushing ? '0 : i_s_axis_tdata;
    assign col0     = (r_in_col == '0);
    assign emit     = col0 ? (r_in_row >= FHW'(2)) : (r_in_row >= FHW'(1));
    assign last     = flushing && ({1'b0, r_in_row} >= ({1'b0, h_eff} + (FHW+1)'(1)));

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (act) begin
            if (emit) begin
                if ((FWW'(r_out_col) + FWW'(1)) >= w_eff) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + FHW'(1);
                end else begin
                    n_out_col = r_out_col + AW'(1);
                end
            end
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if ((FWW'(r_in_col) + FWW'(1)) >= w_eff) begin
                n_in_col = '0;
                n_in_row = r_in_row + FHW'(1);
            end else begin
                n_in_col = r_in_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_s1_valid <= act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (act) begin
            r_s1_x    <= x_in;
            r_s1_addr <= r_in_col;
            r_s1_emit <= emit;
            r_s1_last <= last;
            r_s1_col0 <= col0;
            r_s1_ocol <= r_out_col;
            r_s1_orow <= r_out_row;
            // column written back this cycle is read again: forward it
            r_s1_fwd  <= r_s1_valid && (r_s1_addr == r_in_col);
        end
    end

    // Line stores: read at accept, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_up[r_s1_addr]  <= mid_eff;
            mem_mid[r_s1_addr] <= r_s1_x;
        end
        if (act) begin
            r_up_q  <= mem_up[r_in_col];
            r_mid_q <= mem_mid[r_in_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fw_up  <= mid_eff;
            r_fw_mid <= r_s1_x;
        end
    end

    assign up_eff  = r_s1_fwd ? r_fw_up  : r_up_q;
    assign mid_eff = r_s1_fwd ? r_fw_mid : r_mid_q;

    // Window shift and masked sum
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = up_eff;
        n_win[1][2] = mid_eff;
        n_win[2][2] = r_s1_x;
    end

    assign top_ok   = (r_s1_orow != '0);
    assign bot_ok   = ({1'b0, r_s1_orow} + (FHW+1)'(1)) < {1'b0, h_eff};
    assign left_ok  = (r_s1_ocol != '0);
    assign right_ok = !r_s1_col0 && ((FWW'(r_s1_ocol) + FWW'(1)) < w_eff);

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = (left_ok ? 10'(n_win[r][0]) : 10'd0) + 10'(n_win[r][1])
                       + (right_ok ? 10'(n_win[r][2]) : 10'd0);
        end
        sum = (top_ok ? 12'(row_sum[0]) : 12'd0) + 12'(row_sum[1])
            + (bot_ok ? 12'(row_sum[2]) : 12'd0);
        rows  = 2'd1 + 2'(top_ok) + 2'(bot_ok);
        cols  = 2'd1 + 2'(left_ok) + 2'(right_ok);
        cnt_n = {2'b00, rows} * {2'b00, cols};
        num   = {sum, 8'h00} + hbs_pkg::NUM_W'(cnt_n >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // Divide by count through an exact reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_last  <= r_s1_last;
        r_s2_num   <= num;
        r_s2_recip <= hbs_pkg::recip(cnt_n);
        r_s3_last  <= r_s2_last;
        r_s3_prod  <= hbs_pkg::PROD_W'(r_s2_num) * hbs_pkg::PROD_W'(r_s2_recip);
    end

    // Output queue
    assign q_pop = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            q_mem[r_q_wr] <= {r_s3_last,
                r_s3_prod[hbs_pkg::RECIP_SHIFT +: hbs_pkg::MEAN_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_rd  <= '0;
            r_q_wr  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (r_s3_valid) begin
                r_q_wr <= r_q_wr + hbs_pkg::FIFO_AW'(1);
            end
            if (q_pop) begin
                r_q_rd <= r_q_rd + hbs_pkg::FIFO_AW'(1);
            end
            case ({r_s3_valid, q_pop})
                2'b10:   r_q_cnt <= r_q_cnt + (hbs_pkg::FIFO_AW+1)'(1);
                2'b01:   r_q_cnt <= r_q_cnt - (hbs_pkg::FIFO_AW+1)'(1);
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

    assign o_m_axis_tvalid = (r_q_cnt != '0);
    assign o_m_axis_tdata  = q_mem[r_q_rd][hbs_pkg::MEAN_W-1:0];
    assign o_m_axis_tlast  = q_mem[r_q_rd][QW-1];

endmodule

// ===== hdl/hbs_checker.sv =====
// Port-level checks for heightmap_box_smoother_top, bound to the top level.
// Depends on hbs_pkg and heightmap_box_smoother_top_macros.svh.
`include "heightmap_box_smoother_top_macros.svh"

module hbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    `HBS_ASSERT_NEXT(a_out_valid_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "output item dropped while stalled")
    `HBS_ASSERT_NEXT(a_out_data_hold, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "output item changed while stalled")
    `HBS_ASSERT_NOW(a_mean_range, o_m_axis_tvalid, o_m_axis_tdata <= hbs_pkg::MEAN_MAX, "mean above 255.0")
    `HBS_ASSERT_NOW(a_ready_backlog, !o_s_axis_tready, o_m_axis_tvalid, "input held off with no output item pending")

endmodule

bind heightmap_box_smoother_top hbs_checker u_hbs_checker (.*);

// ===== tb/sv/heightmap_box_smoother_top_tb.sv =====
// Testbench for heightmap_box_smoother_top: directed and random raster frames
// with flush items, checked against an in-bench 3x3 edge-normalized mean.
// Depends on hbs_pkg and the heightmap_box_smoother_top RTL.
module heightmap_box_smoother_top_tb;

    localparam int MEAN_W       = hbs_pkg::MEAN_W;
    localparam int PIX_W        = hbs_pkg::PIX_W;
    localparam int FW_W         = hbs_pkg::FW_W;
    localparam int FH_W         = hbs_pkg::FH_W;
    localparam int CFG_W        = hbs_pkg::CFG_W;
    localparam int MAX_WIDTH    = hbs_pkg::MAX_WIDTH;
    localparam int HEIGHT_LIMIT = hbs_pkg::HEIGHT_LIMIT;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              frame_end;
    } t_smoothed_pixel;

    class box_mean_scoreboard;
        logic [FW_W-1:0]  width_reg;
        logic [FH_W-1:0]  height_reg;
        logic [PIX_W-1:0] older_line [MAX_WIDTH];
        logic [PIX_W-1:0] newer_line [MAX_WIDTH];
        logic [PIX_W-1:0] win [3][3];
        int unsigned      col_in;
        int unsigned      col_out;
        logic [FH_W-1:0]  row_in;
        logic [FH_W-1:0]  row_out;
        t_smoothed_pixel  pending_means [$];
        int unsigned      errors;

        function new();
            width_reg  = hbs_pkg::FW_RESET;
            height_reg = hbs_pkg::FH_RESET;
            foreach (older_line[i]) begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            foreach (win[r, c]) win[r][c] = '0;
            col_in  = 0;
            col_out = 0;
            row_in  = '0;
            row_out = '0;
            errors  = 0;
        endfunction

        function void set_reg(input logic idx, input logic [CFG_W-1:0] value);
            if (idx == hbs_pkg::CFG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
            else height_reg = value[FH_W-1:0];
        endfunction

        function int unsigned active_width();
            int unsigned w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int unsigned active_height();
            int unsigned h;
            h = height_reg;
            if (h == 0) h = 1;
            if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
            return h;
        endfunction

        function void push_column(input logic [PIX_W-1:0] top, input logic [PIX_W-1:0] mid,
                                  input logic [PIX_W-1:0] bot);
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = bot;
        endfunction

        // base is the window column that holds out column - 1
        function logic [MEAN_W-1:0] window_average(input int base, input int unsigned w,
                                                   input int unsigned h);
            int unsigned sum;
            int unsigned n;
            int          wc;
            sum = 0;
            n   = 0;
            for (int dr = 0; dr < 3; dr++) begin
                if (dr == 0 && row_out < 1) continue;
                if (dr == 2 && row_out + 1 >= h) continue;
                for (int dc = 0; dc < 3; dc++) begin
                    wc = base + dc;
                    if (wc > 2) continue;
                    if (dc == 0 && col_out < 1) continue;
                    if (dc == 2 && col_out + 1 >= w) continue;
                    sum += win[dr][wc];
                    n++;
                end
            end
            if (n == 0) n = 1;
            return MEAN_W'((sum * 256 + n / 2) / n);
        endfunction

        function void note_sample(input logic [PIX_W-1:0] height, input logic pad);
            int unsigned     w;
            int unsigned     h;
            int unsigned     c;
            logic            flushing;
            logic            col0;
            logic            emit;
            logic            last;
            logic [PIX_W-1:0] x;
            logic [PIX_W-1:0] up;
            logic [PIX_W-1:0] mid;
            t_smoothed_pixel px;
            w = active_width();
            h = active_height();
            flushing = row_in >= h;
            if (!flushing && pad) return;
            x = flushing ? '0 : height;
            c = col_in;
            up  = older_line[c];
            mid = newer_line[c];
            older_line[c] = mid;
            newer_line[c] = x;
            col0 = col_in == 0;
            emit = (!col0 && row_in >= 1) || (col0 && row_in >= 2);
            last = flushing && row_in >= h + 1;
            px.mean = '0;
            px.frame_end = last;
            if (col0) begin
                if (emit) px.mean = window_average(1, w, h);
                push_column(up, mid, x);
            end else begin
                push_column(up, mid, x);
                if (emit) px.mean = window_average(0, w, h);
            end
            if (emit) begin
                pending_means = {pending_means, px};
                col_out++;
                if (col_out >= w) begin
                    col_out = 0;
                    row_out++;
                end
            end
            if (last) begin
                col_in  = 0;
                row_in  = '0;
                col_out = 0;
                row_out = '0;
            end else begin
                col_in++;
                if (col_in >= w) begin
                    col_in = 0;
                    row_in++;
                end
            end
        endfunction

        function void check_mean(input logic [MEAN_W-1:0] mean, input logic frame_end);
            t_smoothed_pixel want;
            if (pending_means.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: mean %h frame_end %b", mean, frame_end);
                errors++;
                return;
            end
            want = pending_means.pop_front();
            if (want.mean !== mean || want.frame_end !== frame_end) begin
                if (errors < 10)
                    $display("mismatch: mean exp %h got %h, frame_end exp %b got %b",
                             want.mean, mean, want.frame_end, frame_end);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [PIX_W-1:0]  s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [MEAN_W-1:0] m_tdata;
    logic              m_tlast;
    bit                src_fast = 1'b0;
    bit                snk_fast = 1'b0;
    int unsigned       items_sent = 0;
    box_mean_scoreboard sb;

    heightmap_box_smoother_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Called and returns at a falling edge.
    task automatic send_item(input logic [PIX_W-1:0] height, input logic pad);
        int unsigned gap;
        gap = src_fast ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 49) == 0) src_fast = !src_fast;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= height;
        s_tuser  <= pad;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_sample(height, pad);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_means.size() != 0) @(posedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic set_frame_size(input int unsigned w, input int unsigned h);
        cfg_we    <= 1'b1;
        cfg_addr  <= hbs_pkg::CFG_FRAME_WIDTH;
        cfg_wdata <= CFG_W'(w);
        sb.set_reg(hbs_pkg::CFG_FRAME_WIDTH, CFG_W'(w));
        @(negedge clk);
        cfg_addr  <= hbs_pkg::CFG_FRAME_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        sb.set_reg(hbs_pkg::CFG_FRAME_HEIGHT, CFG_W'(h));
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Samples with stray pads mixed in, then a flush where pad is random.
    task automatic run_frame();
        int unsigned w;
        int unsigned h;
        w = sb.active_width();
        h = sb.active_height();
        for (int unsigned i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 19) == 0) send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
            send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
        end
        for (int unsigned i = 0; i <= w; i++)
            send_item(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin : result_sink
        int unsigned gap;
        int unsigned seen;
        seen = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            // long hold-offs let the output queue fill and back up the input
            if (seen == 40 || seen == 300) gap = 400;
            else gap = snk_fast ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 49) == 0) snk_fast = !snk_fast;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            sb.check_mean(m_tdata, m_tlast);
            seen++;
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int unsigned frames;
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = hbs_pkg::CFG_FRAME_WIDTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_frame_size(3, 3);
        send_item(8'hFF, 1'b1);     // pad before the frame: ignored
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd17, 1'b1);     // pad mid-frame: ignored
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd128, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd1, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'hAA, 1'b0);     // sample during flush acts as a pad
        send_item(8'd0, 1'b1);
        send_item(8'h55, 1'b1);
        send_item(8'h3C, 1'b1);     // pad between frames: ignored
        settle();
        set_frame_size(0, 0);       // both sizes act as 1
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'h81, 1'b0);
        settle();

        while (items_sent < 600) begin
            if ($urandom_range(0, 7) == 0)
                set_frame_size($urandom_range(0, 2), $urandom_range(0, 1));
            else set_frame_size($urandom_range(1, 12), $urandom_range(1, 8));
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames && items_sent < 600; f++)
                run_frame();
            settle();
        end

        if (sb.errors == 0 && sb.pending_means.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
